/* rtl/core/cbb_pkg.sv */
`default_nettype none
package cbb_pkg;

  // Default sizing of the slot table and of the byte counters.
  localparam int SLOTS_DEF     = 32;
  localparam int SIZE_BITS_DEF = 24;

  // Fixed field widths of the words on the ports.
  localparam int FIELD_W    = 24;
  localparam int SLOT_W     = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int LOAD_W     = 7;

  // Widest byte counter and widest slot compare the design supports.
  localparam int SIZE_MAX_W = 40;
  localparam int SLOT_CMP_W = 11;

  // Load limit is a percentage.
  localparam int LOAD_SCALE = 100;

  // Register reset values, truncated to the counter width where they are used.
  localparam logic [SIZE_MAX_W-1:0] BUDGET_RST   = 40'd131072;
  localparam logic [SIZE_MAX_W-1:0] MAX_SIZE_RST = 40'd8500;
  localparam logic [LOAD_W-1:0]     MAX_LOAD_RST = 7'd60;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BYTE_BUDGET   = 2'd0,
    CFG_MAX_ITEM_SIZE = 2'd1,
    CFG_MAX_LOAD      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_TOUCH   = 2'd0,
    REQ_ROOM    = 2'd1,
    REQ_INSTALL = 2'd2,
    REQ_FULL    = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    STS_TOUCHED    = 3'd0,
    STS_ROOM_READY = 3'd1,
    STS_VICTIM     = 3'd2,
    STS_TOO_BIG    = 3'd3,
    STS_LOAD_OVER  = 3'd4,
    STS_INSTALLED  = 3'd5
  } sts_t;

  // Request and result words.
  typedef struct packed {
    logic [1:0]         req_type;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] item_size;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  victim_slot;
    logic [FIELD_W-1:0] freed_bytes;
    logic [FIELD_W-1:0] bytes_in_use;
    logic               last;
  } rsp_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_RD_SLOT,
    OP_TOUCH_WR,
    OP_INST_SUB,
    OP_INST_ADD,
    OP_SWEEP_START,
    OP_SWEEP,
    OP_N_CLR,
    OP_N_INC
  } op_t;

  // Branch conditions tested by the sequencer.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_CNT_LAST,
    C_LOAD_OVER,
    C_TOO_BIG,
    C_FITS,
    C_N_FULL,
    C_SWEEP_DONE,
    C_VICTIM
  } cond_t;

  localparam int PC_W = 5;

  // Program addresses.
  localparam logic [PC_W-1:0] P_CLR    = 5'd0;
  localparam logic [PC_W-1:0] P_IDLE   = 5'd1;
  localparam logic [PC_W-1:0] P_CHK    = 5'd2;
  localparam logic [PC_W-1:0] P_DSP    = 5'd3;
  localparam logic [PC_W-1:0] P_LOAD   = 5'd4;
  localparam logic [PC_W-1:0] P_TCH0   = 5'd5;
  localparam logic [PC_W-1:0] P_TCH1   = 5'd6;
  localparam logic [PC_W-1:0] P_TCH2   = 5'd7;
  localparam logic [PC_W-1:0] P_INS0   = 5'd8;
  localparam logic [PC_W-1:0] P_INS1   = 5'd9;
  localparam logic [PC_W-1:0] P_INS2   = 5'd10;
  localparam logic [PC_W-1:0] P_INS3   = 5'd11;
  localparam logic [PC_W-1:0] P_RM0    = 5'd12;
  localparam logic [PC_W-1:0] P_RM1    = 5'd13;
  localparam logic [PC_W-1:0] P_RM2    = 5'd14;
  localparam logic [PC_W-1:0] P_RM3    = 5'd15;
  localparam logic [PC_W-1:0] P_RM4    = 5'd16;
  localparam logic [PC_W-1:0] P_FL0    = 5'd17;
  localparam logic [PC_W-1:0] P_FL1    = 5'd18;
  localparam logic [PC_W-1:0] P_FL2    = 5'd19;
  localparam logic [PC_W-1:0] P_READY  = 5'd20;
  localparam logic [PC_W-1:0] P_TOOBIG = 5'd21;

  // One control word per program step.
  typedef struct packed {
    op_t             op;
    logic            wait_in;
    logic            emit;
    sts_t            sts;
    logic            last;
    logic            use_victim;
    logic            dispatch;
    logic            hold;
    cond_t           c1;
    logic [PC_W-1:0] t1;
    cond_t           c2;
    logic [PC_W-1:0] t2;
  } uword_t;

  // Control word plus the step-advance strobe, sequencer to datapath.
  typedef struct packed {
    uword_t uw;
    logic   go;
  } step_ctl_t;

  // Condition flags, datapath to sequencer.
  typedef struct packed {
    logic [1:0] req_kind;
    logic       cnt_last;
    logic       load_over;
    logic       too_big;
    logic       fits;
    logic       n_full;
    logic       sweep_done;
    logic       victim;
    logic       out_free;
  } flags_t;

  // Entry step of each request kind.
  function automatic logic [PC_W-1:0] dispatch_pc(input logic [1:0] kind);
    logic [PC_W-1:0] tgt;
    case (kind)
      REQ_TOUCH:   tgt = P_TCH0;
      REQ_ROOM:    tgt = P_RM0;
      REQ_INSTALL: tgt = P_INS0;
      REQ_FULL:    tgt = P_FL0;
      default:     tgt = P_IDLE;
    endcase
    return tgt;
  endfunction

  // Control store.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t uw;
    uw = '0;
    case (pc)
      P_CLR: begin
        uw.op = OP_CLEAR;
        uw.c1 = C_CNT_LAST;
        uw.t1 = P_IDLE;
        uw.hold = 1'b1;
      end
      P_IDLE: begin
        uw.op = OP_ACCEPT;
        uw.wait_in = 1'b1;
      end
      P_CHK: begin
        uw.c1 = C_LOAD_OVER;
        uw.t1 = P_LOAD;
      end
      P_DSP: begin
        uw.dispatch = 1'b1;
      end
      P_LOAD: begin
        uw.emit = 1'b1;
        uw.sts = STS_LOAD_OVER;
        uw.last = 1'b1;
        uw.c1 = C_ALWAYS;
        uw.t1 = P_IDLE;
      end
      P_TCH0: begin
        uw.op = OP_RD_SLOT;
      end
      P_TCH1: begin
        uw.op = OP_TOUCH_WR;
      end
      P_TCH2: begin
        uw.emit = 1'b1;
        uw.sts = STS_TOUCHED;
        uw.last = 1'b1;
        uw.c1 = C_ALWAYS;
        uw.t1 = P_IDLE;
      end
      P_INS0: begin
        uw.op = OP_RD_SLOT;
      end
      P_INS1: begin
        uw.op = OP_INST_SUB;
      end
      P_INS2: begin
        uw.op = OP_INST_ADD;
      end
      P_INS3: begin
        uw.emit = 1'b1;
        uw.sts = STS_INSTALLED;
        uw.last = 1'b1;
        uw.c1 = C_ALWAYS;
        uw.t1 = P_IDLE;
      end
      P_RM0: begin
        uw.op = OP_N_CLR;
        uw.c1 = C_TOO_BIG;
        uw.t1 = P_TOOBIG;
      end
      P_RM1: begin
        uw.c1 = C_FITS;
        uw.t1 = P_READY;
        uw.c2 = C_N_FULL;
        uw.t2 = P_TOOBIG;
      end
      P_RM2: begin
        uw.op = OP_SWEEP_START;
      end
      P_RM3: begin
        uw.op = OP_SWEEP;
        uw.c1 = C_SWEEP_DONE;
        uw.t1 = P_TOOBIG;
        uw.c2 = C_VICTIM;
        uw.t2 = P_RM4;
        uw.hold = 1'b1;
      end
      P_RM4: begin
        uw.op = OP_N_INC;
        uw.emit = 1'b1;
        uw.sts = STS_VICTIM;
        uw.use_victim = 1'b1;
        uw.c1 = C_ALWAYS;
        uw.t1 = P_RM1;
      end
      P_FL0: begin
        uw.op = OP_SWEEP_START;
      end
      P_FL1: begin
        uw.op = OP_SWEEP;
        uw.c1 = C_SWEEP_DONE;
        uw.t1 = P_READY;
        uw.c2 = C_VICTIM;
        uw.t2 = P_FL2;
        uw.hold = 1'b1;
      end
      P_FL2: begin
        uw.emit = 1'b1;
        uw.sts = STS_VICTIM;
        uw.use_victim = 1'b1;
        uw.last = 1'b1;
        uw.c1 = C_ALWAYS;
        uw.t1 = P_IDLE;
      end
      P_READY: begin
        uw.emit = 1'b1;
        uw.sts = STS_ROOM_READY;
        uw.last = 1'b1;
        uw.c1 = C_ALWAYS;
        uw.t1 = P_IDLE;
      end
      P_TOOBIG: begin
        uw.emit = 1'b1;
        uw.sts = STS_TOO_BIG;
        uw.last = 1'b1;
        uw.c1 = C_ALWAYS;
        uw.t1 = P_IDLE;
      end
      default: begin
        uw.c1 = C_ALWAYS;
        uw.t1 = P_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/clock_replacement_byte_budget_core.sv */
// Second-chance (clock) slot replacement under a byte budget. Each request word
// produces one or more result words, the final one marked by last; a make-room
// request yields one victim word per eviction before its closing word. A small
// microprogram steps a single slot table (one write and one registered read per
// cycle), so timing is set by that table. A full-table or make-room request
// lasts longer for each slot the hand passes over, and a make-room request also
// for each victim. One victim search passes at most 2*SLOTS slots. Stalls on
// the result side lengthen a request. Results wait in an output register, and
// the next request is taken while the last result is still pending. After
// reset the table is cleared one slot per cycle, and no request is taken
// until the clear is done; configuration writes are taken at any time and
// belong only in idle periods.
`default_nettype none
module clock_replacement_byte_budget_core #(
  parameter int SLOTS     = cbb_pkg::SLOTS_DEF,
  parameter int SIZE_BITS = cbb_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  cbb_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output cbb_pkg::rsp_t                  rsp,
  input  logic                           cfg_we,
  input  logic [cbb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cbb_pkg::FIELD_W-1:0]    cfg_wdata
);
  import cbb_pkg::*;

  step_ctl_t ctl;
  flags_t    flags;

  // Microprogram sequencer.
  cbb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .flags    (flags),
    .ctl      (ctl)
  );

  // Slot table, counters and result register.
  cbb_dp #(
    .SLOTS    (SLOTS),
    .SIZE_BITS(SIZE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .rsp_ready(rsp_ready),
    .flags    (flags),
    .rsp_valid(rsp_valid),
    .rsp      (rsp)
  );

  // A request word is taken only in the idle step of the program.
  assign req_ready = ctl.uw.wait_in;

`ifndef ASSERT_OFF
  // Once a word is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still in progress");

  // Only a victim word can be followed by more words of the same request.
  a_final_unless_victim: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STS_VICTIM |-> rsp.last)
    else $error("non-victim result not marked last");

  // Victim fields are zero on every result other than an eviction.
  a_victim_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STS_VICTIM |-> rsp.victim_slot == '0 && rsp.freed_bytes == '0)
    else $error("victim fields set on a non-victim result");
`endif

endmodule
`default_nettype wire

/* rtl/core/cbb_ram.sv */
`default_nettype none
module cbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/cbb_seq.sv */
`default_nettype none
module cbb_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  cbb_pkg::flags_t    flags,
  output cbb_pkg::step_ctl_t ctl
);
  import cbb_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            stall;

  function automatic logic cond_hit(input cond_t c, input flags_t f);
    logic hit;
    case (c)
      C_NONE:       hit = 1'b0;
      C_ALWAYS:     hit = 1'b1;
      C_CNT_LAST:   hit = f.cnt_last;
      C_LOAD_OVER:  hit = f.load_over;
      C_TOO_BIG:    hit = f.too_big;
      C_FITS:       hit = f.fits;
      C_N_FULL:     hit = f.n_full;
      C_SWEEP_DONE: hit = f.sweep_done;
      C_VICTIM:     hit = f.victim;
      default:      hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_CLR;
    end else begin
      pc <= pc_next;
    end
  end

  // Fetch the control word, then pick the next step: a step waits for an
  // input word or for room in the result register, then branches.
  always_comb begin
    uw = ucode(pc);
    stall = (uw.wait_in && !req_valid) || (uw.emit && !flags.out_free);
    pc_next = pc + 1'b1;
    if (stall) begin
      pc_next = pc;
    end else if (uw.dispatch) begin
      pc_next = dispatch_pc(flags.req_kind);
    end else if (cond_hit(uw.c1, flags)) begin
      pc_next = uw.t1;
    end else if (cond_hit(uw.c2, flags)) begin
      pc_next = uw.t2;
    end else if (uw.hold) begin
      pc_next = pc;
    end
    ctl.uw = uw;
    ctl.go = !stall;
  end

endmodule
`default_nettype wire

/* rtl/core/cbb_dp.sv */
`default_nettype none
module cbb_dp #(
  parameter int SLOTS     = cbb_pkg::SLOTS_DEF,
  parameter int SIZE_BITS = cbb_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cbb_pkg::step_ctl_t               ctl,
  input  cbb_pkg::req_t                    req,
  input  logic                             cfg_we,
  input  logic [cbb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cbb_pkg::FIELD_W-1:0]      cfg_wdata,
  input  logic                             rsp_ready,
  output cbb_pkg::flags_t                  flags,
  output logic                             rsp_valid,
  output cbb_pkg::rsp_t                    rsp
);
  import cbb_pkg::*;

  localparam int SW      = SIZE_BITS;
  localparam int AW      = $clog2(SLOTS);
  localparam int CW      = $clog2(2 * SLOTS + 1);
  localparam int NW      = $clog2(SLOTS + 1);
  localparam int LW      = $clog2(128 * SLOTS + 1);
  localparam int RW      = SW + 2;
  localparam int OCC_BIT = SW + 1;
  localparam int REF_BIT = SW;

  uword_t uw;
  logic   go;

  // Configuration registers.
  logic [SW-1:0]     budget;
  logic [SW-1:0]     max_item;
  logic [LOAD_W-1:0] max_load;

  // Block state.
  req_t          req_r;
  logic [AW-1:0] hand;
  logic [SW-1:0] bytes_used;
  logic [NW-1:0] entries_used;
  logic [CW-1:0] cnt;
  logic [NW-1:0] n_cnt;
  logic [AW-1:0] victim_r;
  logic [SW-1:0] freed_r;

  // Slot table port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] rd_data;

  logic                  rd_occ;
  logic                  rd_ref;
  logic [SW-1:0]         rd_len;
  logic [SLOT_CMP_W-1:0] slot_wide;
  logic                  slot_ok;
  logic [AW-1:0]         slot_addr;
  logic [SIZE_MAX_W-1:0] size_wide;
  logic [SW-1:0]         size_m;
  logic [SIZE_MAX_W-1:0] cfg_wide;
  logic [AW-1:0]         hand_inc;
  logic [SW-1:0]         bytes_less;
  logic [SW:0]           bytes_sum;
  logic [SW-1:0]         bytes_sat;
  logic                  sweep_done;
  logic                  victim_hit;
  logic [LW-1:0]         load_lhs;
  logic [LW-1:0]         load_rhs;
  logic [SLOT_CMP_W-1:0] victim_wide;
  logic [SIZE_MAX_W-1:0] freed_wide;
  logic [SIZE_MAX_W-1:0] bytes_wide;

  assign uw = ctl.uw;
  assign go = ctl.go;

  // Field decode of the table entry and of the held request.
  assign rd_occ    = rd_data[OCC_BIT];
  assign rd_ref    = rd_data[REF_BIT];
  assign rd_len    = rd_data[SW-1:0];
  assign slot_wide = SLOT_CMP_W'(req_r.slot);
  assign slot_ok   = slot_wide < SLOT_CMP_W'(SLOTS);
  assign slot_addr = slot_wide[AW-1:0];
  assign size_wide = SIZE_MAX_W'(req_r.item_size);
  assign size_m    = size_wide[SW-1:0];
  assign cfg_wide  = SIZE_MAX_W'(cfg_wdata);

  // Clock hand advance with wrap.
  assign hand_inc = (hand == AW'(SLOTS - 1)) ? '0 : hand + 1'b1;

  // Byte counter arithmetic: release with floor at zero, add with saturation.
  assign bytes_less = (bytes_used > rd_len) ? bytes_used - rd_len : '0;
  assign bytes_sum  = {1'b0, bytes_used} + {1'b0, size_m};
  assign bytes_sat  = bytes_sum[SW] ? '1 : bytes_sum[SW-1:0];

  // Sweep status: the hand has made two full turns, or sits on a slot to evict.
  assign sweep_done = cnt == CW'(2 * SLOTS);
  assign victim_hit = rd_occ && !rd_ref;

  // Load check without division: entries*100/SLOTS > limit exactly when
  // entries*100 >= (limit+1)*SLOTS.
  assign load_lhs = LW'(entries_used) * LW'(LOAD_SCALE);
  assign load_rhs = (LW'(max_load) + LW'(1)) * LW'(SLOTS);

  always_comb begin
    flags.req_kind   = req_r.req_type;
    flags.cnt_last   = cnt == CW'(SLOTS - 1);
    flags.load_over  = load_lhs >= load_rhs;
    flags.too_big    = (size_m > max_item) || (size_m > budget);
    flags.fits       = {1'b0, budget} >= bytes_sum;
    flags.n_full     = n_cnt == NW'(SLOTS);
    flags.sweep_done = sweep_done;
    flags.victim     = victim_hit;
    flags.out_free   = !rsp_valid || rsp_ready;
  end

  // Slot table addressing and write data per operation.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hand;
    ram_wdata = {1'b0, 1'b0, rd_len};
    ram_raddr = hand;
    case (uw.op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
        ram_wdata = '0;
      end
      OP_RD_SLOT: begin
        ram_raddr = slot_addr;
      end
      OP_TOUCH_WR: begin
        ram_we    = slot_ok && rd_occ;
        ram_waddr = slot_addr;
        ram_wdata = {1'b1, 1'b1, rd_len};
      end
      OP_INST_SUB: begin
        ram_we    = slot_ok;
        ram_waddr = slot_addr;
        ram_wdata = {1'b1, 1'b1, size_m};
      end
      OP_SWEEP: begin
        // Read one slot ahead; a referenced slot keeps its entry with the
        // bit cleared, a victim is marked evicted.
        ram_raddr = hand_inc;
        ram_we    = !sweep_done && rd_occ;
        ram_wdata = {rd_ref, 1'b0, rd_len};
      end
      default: begin
        ram_raddr = hand;
      end
    endcase
    ram_we = ram_we && go;
  end

  cbb_ram #(
    .WIDTH(RW),
    .DEPTH(SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  // Control state: configuration, counters, hand and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      budget       <= BUDGET_RST[SW-1:0];
      max_item     <= MAX_SIZE_RST[SW-1:0];
      max_load     <= MAX_LOAD_RST;
      hand         <= '0;
      bytes_used   <= '0;
      entries_used <= '0;
      cnt          <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BYTE_BUDGET:   budget   <= cfg_wide[SW-1:0];
          CFG_MAX_ITEM_SIZE: max_item <= cfg_wide[SW-1:0];
          CFG_MAX_LOAD:      max_load <= cfg_wdata[LOAD_W-1:0];
          default: begin
          end
        endcase
      end

      if (go) begin
        case (uw.op)
          OP_CLEAR: begin
            cnt <= cnt + 1'b1;
          end
          OP_INST_SUB: begin
            if (slot_ok) begin
              if (rd_occ) begin
                bytes_used <= bytes_less;
              end else begin
                entries_used <= entries_used + 1'b1;
              end
            end
          end
          OP_INST_ADD: begin
            if (slot_ok) begin
              bytes_used <= bytes_sat;
            end
          end
          OP_SWEEP_START: begin
            cnt <= '0;
          end
          OP_SWEEP: begin
            if (!sweep_done) begin
              if (victim_hit) begin
                bytes_used <= bytes_less;
                if (entries_used != '0) begin
                  entries_used <= entries_used - 1'b1;
                end
              end else begin
                hand <= hand_inc;
                cnt  <= cnt + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (go && uw.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign victim_wide = SLOT_CMP_W'(victim_r);
  assign freed_wide  = SIZE_MAX_W'(freed_r);
  assign bytes_wide  = SIZE_MAX_W'(bytes_used);

  // Payload registers: held request, eviction count, last victim, result word.
  always_ff @(posedge clk) begin
    if (go && uw.op == OP_ACCEPT) begin
      req_r <= req;
    end
    if (go && uw.op == OP_N_CLR) begin
      n_cnt <= '0;
    end else if (go && uw.op == OP_N_INC) begin
      n_cnt <= n_cnt + 1'b1;
    end
    if (go && uw.op == OP_SWEEP && !sweep_done && victim_hit) begin
      victim_r <= hand;
      freed_r  <= rd_len;
    end
    if (go && uw.emit) begin
      rsp.status       <= uw.sts;
      rsp.victim_slot  <= uw.use_victim ? victim_wide[SLOT_W-1:0] : '0;
      rsp.freed_bytes  <= uw.use_victim ? freed_wide[FIELD_W-1:0] : '0;
      rsp.bytes_in_use <= bytes_wide[FIELD_W-1:0];
      rsp.last         <= uw.last;
    end
  end

endmodule
`default_nettype wire
